// ===== design/lsa_pkg.sv =====
`default_nettype none

package lsa_pkg;

  // Default maximum sequence lengths
  localparam int MaxQueryLenDef = 32;
  localparam int MaxRefLenDef   = 32;

  // Field widths
  localparam int SymW   = 8;
  localparam int ScoreW = 12;
  localparam int PosW   = 6;
  localparam int CfgW   = 8;
  localparam int PaddrW = 4;
  localparam int PdataW = 32;

  localparam logic [ScoreW-1:0] ScoreCap = 12'd4064;

  // Register indexes (word address)
  localparam logic [1:0] REG_GAP      = 2'd0;
  localparam logic [1:0] REG_MATCH    = 2'd1;
  localparam logic [1:0] REG_MISMATCH = 2'd2;

  localparam logic signed [CfgW-1:0] GapRst      = -8'sd2;
  localparam logic signed [CfgW-1:0] MatchRst    = 8'sd2;
  localparam logic signed [CfgW-1:0] MismatchRst = -8'sd1;

  // Traceback directions
  localparam logic [1:0] DIR_DIAG = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_LEFT = 2'd2;
  localparam logic [1:0] DIR_STOP = 2'd3;

  // Result step kinds
  localparam logic [1:0] KIND_MATCH    = 2'd0;
  localparam logic [1:0] KIND_MISMATCH = 2'd1;
  localparam logic [1:0] KIND_GAP_REF  = 2'd2;
  localparam logic [1:0] KIND_GAP_QRY  = 2'd3;

  typedef enum logic [0:0] {
    OP_REF_LOAD = 1'b0,
    OP_QUERY    = 1'b1
  } op_e;

  typedef struct packed {
    logic            cmd;
    logic [SymW-1:0] symbol;
    logic            last;
  } in_item_t;

  typedef struct packed {
    logic [SymW-1:0]   sym_query;
    logic [SymW-1:0]   sym_ref;
    logic [1:0]        step_kind;
    logic [ScoreW-1:0] best_score;
    logic [PosW-1:0]   end_row;
    logic [PosW-1:0]   end_col;
    logic              found;
    logic              overflow;
    logic              done_res;
  } out_item_t;

  // Classified operation handed from front to back
  typedef struct packed {
    op_e             op;
    logic [SymW-1:0] symbol;
    logic            last;
  } lsa_op_t;

  typedef struct packed {
    logic signed [CfgW-1:0] gap;
    logic signed [CfgW-1:0] match;
    logic signed [CfgW-1:0] mismatch;
  } lsa_cfg_t;

endpackage

`default_nettype wire

// ===== design/lsa_ram.sv =====
`default_nettype none

module lsa_ram #(
  parameter int Width = 2,
  parameter int Depth = 1024
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                       wdata_i,
  input  wire logic                                   re_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== design/lsa_front.sv =====
`default_nettype none

module lsa_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire lsa_pkg::in_item_t in_data_i,
  output logic                   op_valid_o,
  input  wire logic              op_ready_i,
  output lsa_pkg::lsa_op_t       op_o
);
  import lsa_pkg::*;

  lsa_op_t    fifo_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  lsa_op_t    op_c;

  // Classify the incoming transfer
  always_comb begin
    op_c.op     = in_data_i.cmd ? OP_QUERY : OP_REF_LOAD;
    op_c.symbol = in_data_i.symbol;
    op_c.last   = in_data_i.last;
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign op_valid_o = (cnt_q != 2'd0);
  assign op_o       = fifo_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = op_ready_i && op_valid_o;

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store queue entries
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= op_c;
    end
  end

endmodule

`default_nettype wire

// ===== design/lsa_back.sv =====
`default_nettype none

module lsa_back #(
  parameter int MaxQueryLen = lsa_pkg::MaxQueryLenDef,
  parameter int MaxRefLen   = lsa_pkg::MaxRefLenDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire lsa_pkg::lsa_cfg_t  cfg_i,
  input  wire logic               op_valid_i,
  output logic                    op_ready_o,
  input  wire lsa_pkg::lsa_op_t   op_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output lsa_pkg::out_item_t      out_data_o
);
  import lsa_pkg::*;

  localparam int RIW      = (MaxRefLen > 1) ? $clog2(MaxRefLen) : 1;
  localparam int QIW      = (MaxQueryLen > 1) ? $clog2(MaxQueryLen) : 1;
  localparam int DirDepth = MaxQueryLen * MaxRefLen;
  localparam int DirAw    = (DirDepth > 1) ? $clog2(DirDepth) : 1;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_ROW     = 3'd1;
  localparam logic [2:0] ST_TB_ADDR = 3'd2;
  localparam logic [2:0] ST_TB_DATA = 3'd3;
  localparam logic [2:0] ST_TB_LAST = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [PosW-1:0]   col_q, col_d;
  logic [PosW-1:0]   qrow_q, qrow_d;
  logic [PosW-1:0]   tb_row_q, tb_row_d;
  logic [PosW-1:0]   ref_len_q, ref_len_d;
  logic              ref_closed_q, ref_closed_d;
  logic              dropped_q, dropped_d;
  logic [ScoreW-1:0] top_score_q, top_score_d;
  logic [PosW-1:0]   top_row_q, top_row_d;
  logic [PosW-1:0]   top_col_q, top_col_d;
  logic              pend_v_q, pend_v_d;
  out_item_t         pend_q, pend_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;
  logic [SymW-1:0]   cur_sym_q, cur_sym_d;
  logic              last_q, last_d;
  logic [ScoreW-1:0] diag_q, diag_d;
  logic [ScoreW-1:0] left_q, left_d;

  logic [SymW-1:0]   ref_mem_q  [MaxRefLen];
  logic [SymW-1:0]   qsym_mem_q [MaxQueryLen];
  logic [ScoreW-1:0] prev_q     [MaxRefLen];

  logic              ref_we, q_we, prev_we, dir_we, dir_re, start_tb, out_free;
  logic [PosW-1:0]   len_eff;
  logic [RIW-1:0]    col_idx;
  logic [QIW-1:0]    tb_qidx;
  logic [SymW-1:0]   ref_rd, qsym_rd;
  logic [ScoreW-1:0] up_val, cell_c;
  logic [1:0]        dir_c, dir_rd;
  logic [DirAw-1:0]  dir_waddr, dir_raddr;
  logic signed [CfgW-1:0] sc;
  logic signed [13:0]     diag_s, up_s, left_s, best_s;

  function automatic out_item_t make_res(logic [SymW-1:0] sq, logic [SymW-1:0] sr,
                                         logic [1:0] kind, logic fnd,
                                         logic [ScoreW-1:0] score, logic [PosW-1:0] row,
                                         logic [PosW-1:0] col, logic ovf);
    out_item_t r;
    r.sym_query  = sq;
    r.sym_ref    = sr;
    r.step_kind  = kind;
    r.best_score = fnd ? score : '0;
    r.end_row    = fnd ? row : '0;
    r.end_col    = fnd ? col : '0;
    r.found      = fnd;
    r.overflow   = ovf;
    r.done_res   = 1'b0;
    return r;
  endfunction

  assign col_idx  = RIW'(col_q - 6'd1);
  assign tb_qidx  = QIW'(tb_row_q - 6'd1);
  assign ref_rd   = ref_mem_q[col_idx];
  assign qsym_rd  = qsym_mem_q[tb_qidx];
  assign up_val   = (qrow_q == '0) ? '0 : prev_q[col_idx];
  assign len_eff  = ref_closed_q ? '0 : ref_len_q;
  assign out_free = !out_valid_q || out_ready_i;

  assign dir_waddr = DirAw'(32'(qrow_q) * MaxRefLen + 32'(col_idx));
  assign dir_raddr = DirAw'(32'(tb_row_q - 6'd1) * MaxRefLen + 32'(col_idx));

  // Score one cell of the current row
  always_comb begin
    sc     = (cur_sym_q == ref_rd) ? cfg_i.match : cfg_i.mismatch;
    diag_s = $signed({2'b00, diag_q}) + $signed({{6{sc[CfgW-1]}}, sc});
    up_s   = $signed({2'b00, up_val}) + $signed({{6{cfg_i.gap[CfgW-1]}}, cfg_i.gap});
    left_s = $signed({2'b00, left_q}) + $signed({{6{cfg_i.gap[CfgW-1]}}, cfg_i.gap});
    best_s = diag_s;
    dir_c  = DIR_DIAG;
    if (up_s > best_s) begin
      best_s = up_s;
      dir_c  = DIR_UP;
    end
    if (left_s > best_s) begin
      best_s = left_s;
      dir_c  = DIR_LEFT;
    end
    if (best_s < 14'sd0) begin
      cell_c = '0;
      dir_c  = DIR_STOP;
    end else if (best_s > $signed({2'b00, ScoreCap})) begin
      cell_c = ScoreCap;
    end else begin
      cell_c = best_s[ScoreW-1:0];
    end
  end

  // Sequencer: load, row scan, traceback
  always_comb begin
    state_d      = state_q;
    col_d        = col_q;
    qrow_d       = qrow_q;
    tb_row_d     = tb_row_q;
    ref_len_d    = ref_len_q;
    ref_closed_d = ref_closed_q;
    dropped_d    = dropped_q;
    top_score_d  = top_score_q;
    top_row_d    = top_row_q;
    top_col_d    = top_col_q;
    pend_v_d     = pend_v_q;
    pend_d       = pend_q;
    cur_sym_d    = cur_sym_q;
    last_d       = last_q;
    diag_d       = diag_q;
    left_d       = left_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;
    ref_we       = 1'b0;
    q_we         = 1'b0;
    prev_we      = 1'b0;
    dir_we       = 1'b0;
    dir_re       = 1'b0;
    start_tb     = 1'b0;
    op_ready_o   = (state_q == ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        if (op_valid_i) begin
          cur_sym_d = op_i.symbol;
          last_d    = op_i.last;
          if (op_i.op == OP_REF_LOAD) begin
            // Reference symbols are dropped while a query is in progress
            if (qrow_q == '0) begin
              if (len_eff < PosW'(MaxRefLen)) begin
                ref_we    = 1'b1;
                ref_len_d = len_eff + 6'd1;
              end else begin
                ref_len_d = len_eff;
                dropped_d = 1'b1;
              end
              ref_closed_d = op_i.last;
            end
          end else begin
            ref_closed_d = 1'b1;
            if (qrow_q < PosW'(MaxQueryLen)) begin
              q_we    = 1'b1;
              col_d   = 6'd1;
              diag_d  = '0;
              left_d  = '0;
              state_d = ST_ROW;
            end else begin
              dropped_d = 1'b1;
              start_tb  = op_i.last;
            end
          end
        end
      end
      ST_ROW: begin
        if (col_q > ref_len_q) begin
          qrow_d = qrow_q + 6'd1;
          if (last_q) begin
            start_tb = 1'b1;
          end else begin
            state_d = ST_IDLE;
          end
        end else begin
          prev_we = 1'b1;
          dir_we  = 1'b1;
          col_d   = col_q + 6'd1;
          diag_d  = up_val;
          left_d  = cell_c;
          if (cell_c > top_score_q) begin
            top_score_d = cell_c;
            top_row_d   = qrow_q + 6'd1;
            top_col_d   = col_q;
          end
        end
      end
      ST_TB_ADDR: begin
        if ((tb_row_q == '0) || (col_q == '0)) begin
          state_d = ST_TB_LAST;
        end else begin
          dir_re  = 1'b1;
          state_d = ST_TB_DATA;
        end
      end
      ST_TB_DATA: begin
        if (dir_rd == DIR_STOP) begin
          if (!pend_v_q) begin
            pend_d   = make_res('0, '0, KIND_MATCH, 1'b0, '0, '0, '0, dropped_q);
            pend_v_d = 1'b1;
          end
          state_d = ST_TB_LAST;
        end else if (!pend_v_q || out_free) begin
          // Release the previous step, hold the new one until the end is known
          if (pend_v_q) begin
            out_valid_d = 1'b1;
            out_d       = pend_q;
          end
          pend_v_d = 1'b1;
          state_d  = ST_TB_ADDR;
          case (dir_rd)
            DIR_DIAG: begin
              pend_d = make_res(qsym_rd, ref_rd,
                                (qsym_rd == ref_rd) ? KIND_MATCH : KIND_MISMATCH,
                                1'b1, top_score_q, top_row_q, top_col_q, dropped_q);
              tb_row_d = tb_row_q - 6'd1;
              col_d    = col_q - 6'd1;
            end
            DIR_UP: begin
              pend_d = make_res(qsym_rd, '0, KIND_GAP_REF, 1'b1,
                                top_score_q, top_row_q, top_col_q, dropped_q);
              tb_row_d = tb_row_q - 6'd1;
            end
            default: begin
              pend_d = make_res('0, ref_rd, KIND_GAP_QRY, 1'b1,
                                top_score_q, top_row_q, top_col_q, dropped_q);
              col_d = col_q - 6'd1;
            end
          endcase
        end
      end
      ST_TB_LAST: begin
        if (out_free) begin
          // Final step of the run; drop the job state
          out_valid_d    = 1'b1;
          out_d          = pend_q;
          out_d.done_res = 1'b1;
          pend_v_d       = 1'b0;
          qrow_d         = '0;
          top_score_d    = '0;
          top_row_d      = '0;
          top_col_d      = '0;
          dropped_d      = 1'b0;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Launch the traceback from the best cell, or a single found=0 result if none scored
    if (start_tb) begin
      if (top_score_q == '0) begin
        pend_d   = make_res('0, '0, KIND_MATCH, 1'b0, '0, '0, '0, dropped_d);
        pend_v_d = 1'b1;
        state_d  = ST_TB_LAST;
      end else begin
        tb_row_d = top_row_q;
        col_d    = top_col_q;
        state_d  = ST_TB_ADDR;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      col_q        <= '0;
      qrow_q       <= '0;
      tb_row_q     <= '0;
      ref_len_q    <= '0;
      ref_closed_q <= 1'b0;
      dropped_q    <= 1'b0;
      top_score_q  <= '0;
      top_row_q    <= '0;
      top_col_q    <= '0;
      pend_v_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      last_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      col_q        <= col_d;
      qrow_q       <= qrow_d;
      tb_row_q     <= tb_row_d;
      ref_len_q    <= ref_len_d;
      ref_closed_q <= ref_closed_d;
      dropped_q    <= dropped_d;
      top_score_q  <= top_score_d;
      top_row_q    <= top_row_d;
      top_col_q    <= top_col_d;
      pend_v_q     <= pend_v_d;
      out_valid_q  <= out_valid_d;
      last_q       <= last_d;
    end
  end

  // Payload registers and symbol stores
  always_ff @(posedge clk_i) begin
    pend_q    <= pend_d;
    out_q     <= out_d;
    cur_sym_q <= cur_sym_d;
    diag_q    <= diag_d;
    left_q    <= left_d;
    if (ref_we) begin
      ref_mem_q[RIW'(len_eff)] <= op_i.symbol;
    end
    if (q_we) begin
      qsym_mem_q[QIW'(qrow_q)] <= op_i.symbol;
    end
    if (prev_we) begin
      prev_q[col_idx] <= cell_c;
    end
  end

  lsa_ram #(
    .Width(2),
    .Depth(DirDepth)
  ) u_dir_ram (
    .clk_i  (clk_i),
    .we_i   (dir_we),
    .waddr_i(dir_waddr),
    .wdata_i(dir_c),
    .re_i   (dir_re),
    .raddr_i(dir_raddr),
    .rdata_o(dir_rd)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_row_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROW) |-> (col_q <= ref_len_q + 6'd1))
    else $error("row scan column past reference end");

  a_ref_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ref_len_q <= PosW'(MaxRefLen))
    else $error("reference length beyond maximum");

  a_qrow_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qrow_q <= PosW'(MaxQueryLen))
    else $error("query row beyond maximum");

  a_tb_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TB_DATA) |-> ((tb_row_q != '0) && (col_q != '0)))
    else $error("traceback read outside the matrix");

  a_job_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_TB_LAST) && out_free) |=>
      ((qrow_q == '0) && (top_score_q == '0) && out_valid_q && out_q.done_res))
    else $error("job state not cleared after final result");

endmodule

`default_nettype wire

// ===== design/local_sequence_alignment.sv =====
`default_nettype none

// Smith-Waterman local aligner, linear gap. Load the reference one symbol per
// transfer (cmd 0), then stream query symbols (cmd 1); after the query symbol
// marked last, the block emits the traceback from the best cell, one result per
// aligned pair, with done_res on the final one (a single found=0 result if no
// cell scored). A two-entry queue decouples input acceptance from the scoring
// engine. In the engine, one cell unit scans the row of a query symbol one column
// per cycle; each traceback step waits on a registered direction memory read, and
// the traceback waits while the output is stalled. Scores use gap_score,
// match_reward and mismatch_cost at APB offsets 0x0, 0x4 and 0x8.
module local_sequence_alignment #(
  parameter int MaxQueryLen = lsa_pkg::MaxQueryLenDef,
  parameter int MaxRefLen   = lsa_pkg::MaxRefLenDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire lsa_pkg::in_item_t             in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output lsa_pkg::out_item_t                 out_data_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [lsa_pkg::PaddrW-1:0]    paddr,
  input  wire logic [lsa_pkg::PdataW-1:0]    pwdata,
  output logic      [lsa_pkg::PdataW-1:0]    prdata,
  output logic                               pready
);
  import lsa_pkg::*;

  lsa_cfg_t cfg_q, cfg_d;
  logic     op_valid, op_ready, cfg_wr;
  lsa_op_t  op;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (paddr[3:2])
        REG_GAP:      cfg_d.gap      = pwdata[CfgW-1:0];
        REG_MATCH:    cfg_d.match    = pwdata[CfgW-1:0];
        REG_MISMATCH: cfg_d.mismatch = pwdata[CfgW-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  // Register read mux
  always_comb begin
    case (paddr[3:2])
      REG_GAP:      prdata = {{(PdataW-CfgW){1'b0}}, cfg_q.gap};
      REG_MATCH:    prdata = {{(PdataW-CfgW){1'b0}}, cfg_q.match};
      REG_MISMATCH: prdata = {{(PdataW-CfgW){1'b0}}, cfg_q.mismatch};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gap      <= GapRst;
      cfg_q.match    <= MatchRst;
      cfg_q.mismatch <= MismatchRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  lsa_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i (in_data_i),
    .op_valid_o(op_valid),
    .op_ready_i(op_ready),
    .op_o      (op)
  );

  lsa_back #(
    .MaxQueryLen(MaxQueryLen),
    .MaxRefLen  (MaxRefLen)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .op_valid_i (op_valid),
    .op_ready_o (op_ready),
    .op_i       (op),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

// ===== verif/tb_local_sequence_alignment.sv =====
`timescale 1ns / 1ps

module tb_local_sequence_alignment;
  import lsa_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_item_t out_data_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PaddrW-1:0] paddr = '0;
  logic [PdataW-1:0] pwdata = '0;
  logic [PdataW-1:0] prdata;
  logic pready;

  local_sequence_alignment dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk_i = ~clk_i;

  in_item_t symbol_feed[$];
  out_item_t pair_expect[$];
  int errors = 0;
  int send_idle = 0;
  int recv_idle = 0;

  // Aligner mirror: registers and stores
  int gap_v = -2, match_v = 2, mism_v = -1;
  logic [7:0] ref_mem[32];
  logic [7:0] qry_mem[32];
  int row_score[33];
  logic [1:0] dir_mem[32][32];
  int ref_len = 0, qry_row = 0, best = 0, best_row = 0, best_col = 0;
  bit dropped = 0, ref_done = 0;

  function automatic out_item_t make_pair(logic [7:0] sq, logic [7:0] sr, logic [1:0] kind,
                                          bit fnd);
    out_item_t r;
    r.sym_query = sq;
    r.sym_ref = sr;
    r.step_kind = kind;
    r.best_score = fnd ? best[11:0] : '0;
    r.end_row = fnd ? best_row[5:0] : '0;
    r.end_col = fnd ? best_col[5:0] : '0;
    r.found = fnd;
    r.overflow = dropped;
    r.done_res = 1'b0;
    return r;
  endfunction

  task automatic score_row(logic [7:0] q);
    int cur[33];
    int v, alt;
    logic [1:0] d;
    cur[0] = 0;
    for (int j = 1; j <= ref_len; j++) begin
      v = row_score[j-1] + ((q == ref_mem[j-1]) ? match_v : mism_v);
      d = DIR_DIAG;
      alt = row_score[j] + gap_v;
      if (alt > v) begin v = alt; d = DIR_UP; end
      alt = cur[j-1] + gap_v;
      if (alt > v) begin v = alt; d = DIR_LEFT; end
      if (v < 0) begin v = 0; d = DIR_STOP; end
      if (v > 4064) v = 4064;
      cur[j] = v;
      dir_mem[qry_row][j-1] = d;
      if (v > best) begin best = v; best_row = qry_row + 1; best_col = j; end
    end
    for (int j = 1; j <= ref_len; j++) row_score[j] = cur[j];
    qry_row++;
  endtask

  task automatic trace_path();
    out_item_t path[$];
    out_item_t p;
    int i, j;
    i = best_row;
    j = best_col;
    if (best != 0) begin
      while (i > 0 && j > 0 && path.size() < 64 && dir_mem[i-1][j-1] != DIR_STOP) begin
        case (dir_mem[i-1][j-1])
          DIR_DIAG: begin
            path.push_back(make_pair(qry_mem[i-1], ref_mem[j-1],
                                     (qry_mem[i-1] == ref_mem[j-1]) ? KIND_MATCH
                                                                    : KIND_MISMATCH, 1));
            i--; j--;
          end
          DIR_UP: begin
            path.push_back(make_pair(qry_mem[i-1], 8'd0, KIND_GAP_REF, 1));
            i--;
          end
          default: begin
            path.push_back(make_pair(8'd0, ref_mem[j-1], KIND_GAP_QRY, 1));
            j--;
          end
        endcase
      end
    end
    if (path.size() == 0) path.push_back(make_pair(8'd0, 8'd0, KIND_MATCH, 0));
    p = path.pop_back();
    p.done_res = 1'b1;
    path.push_back(p);
    foreach (path[k]) pair_expect.push_back(path[k]);
  endtask

  // Advance the mirror by one accepted transfer
  task automatic align_step(in_item_t it);
    if (it.cmd == OP_REF_LOAD) begin
      if (qry_row != 0) return;
      if (ref_done) begin ref_len = 0; ref_done = 0; end
      if (ref_len < 32) begin ref_mem[ref_len] = it.symbol; ref_len++; end
      else dropped = 1;
      if (it.last) ref_done = 1;
    end else begin
      ref_done = 1;
      if (qry_row < 32) begin
        qry_mem[qry_row] = it.symbol;
        score_row(it.symbol);
      end else dropped = 1;
      if (it.last) begin
        trace_path();
        for (int j = 0; j < 33; j++) row_score[j] = 0;
        qry_row = 0; best = 0; best_row = 0; best_col = 0; dropped = 0;
      end
    end
  endtask

  // Drive input transfers from the feed queue
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) align_step(in_data_i);
      if (!in_valid_i || in_ready_o) begin
        if (symbol_feed.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
          in_data_i <= symbol_feed.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Check result transfers and toggle backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (pair_expect.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data_o);
          errors++;
        end else begin
          if (out_data_o !== pair_expect[0]) begin
            $display("%0t: mismatch expected %p actual %p", $time, pair_expect[0],
                     out_data_o);
            errors++;
          end
          void'(pair_expect.pop_front());
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  task automatic add_sym(bit cmd, logic [7:0] sym, bit last);
    in_item_t it;
    it.cmd = cmd;
    it.symbol = sym;
    it.last = last;
    symbol_feed.push_back(it);
  endtask

  function automatic logic [7:0] pick_sym();
    logic [7:0] alpha[4] = '{8'h41, 8'h43, 8'h47, 8'h54};
    if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
    return alpha[$urandom_range(0, 3)];
  endfunction

  task automatic reg_write(logic [1:0] idx, int val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_GAP: gap_v = 32'(signed'(val[7:0]));
      REG_MATCH: match_v = 32'(signed'(val[7:0]));
      default: mism_v = 32'(signed'(val[7:0]));
    endcase
  endtask

  // Hold until every transfer is in and every result is out, then drain
  task automatic settle();
    while (symbol_feed.size() > 0 || in_valid_i || pair_expect.size() > 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic random_job();
    int rl, ql;
    rl = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 36) : $urandom_range(1, 10);
    ql = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 35) : $urandom_range(1, 10);
    for (int k = 0; k < rl; k++)
      add_sym(OP_REF_LOAD, pick_sym(), (k == rl - 1) && ($urandom_range(0, 7) != 0));
    for (int k = 0; k < ql; k++) begin
      if ($urandom_range(0, 15) == 0)
        add_sym(OP_REF_LOAD, pick_sym(), 1'($urandom_range(0, 1)));
      add_sym(OP_QUERY, pick_sym(), k == ql - 1);
    end
  endtask

  initial begin
    int sent;
    int cfg[6][3] = '{'{-2, 2, -1}, '{127, 127, -128}, '{-128, -128, 127},
                      '{-1, 5, -3}, '{-128, 127, -128}, '{0, 0, 0}};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 3)
        0: begin send_idle = 37; recv_idle = 57; end
        1: begin send_idle = 57; recv_idle = 37; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      if (ph == 3) for (int r = 0; r < 3; r++) cfg[3][r] = $urandom_range(0, 255) - 128;
      reg_write(REG_GAP, cfg[ph][0]);
      reg_write(REG_MATCH, cfg[ph][1]);
      reg_write(REG_MISMATCH, cfg[ph][2]);
      if (ph == 0) begin
        // Query on an empty reference, then edge symbols
        add_sym(OP_QUERY, 8'h00, 1);
        add_sym(OP_REF_LOAD, 8'h00, 0);
        add_sym(OP_REF_LOAD, 8'hff, 1);
        add_sym(OP_QUERY, 8'hff, 0);
        add_sym(OP_REF_LOAD, 8'h41, 0);
        add_sym(OP_QUERY, 8'h00, 1);
        add_sym(OP_QUERY, 8'h12, 1);
        // Unterminated reference closed by a query
        add_sym(OP_REF_LOAD, 8'h41, 0);
        add_sym(OP_REF_LOAD, 8'h43, 0);
        add_sym(OP_QUERY, 8'h41, 0);
        add_sym(OP_QUERY, 8'h43, 1);
        // Overlong reference
        for (int k = 0; k < 34; k++) add_sym(OP_REF_LOAD, pick_sym(), k == 33);
        add_sym(OP_QUERY, 8'h41, 1);
      end
      sent = 0;
      while (sent < 24) begin
        random_job();
        sent += 12;
      end
      settle();
    end
    // Overlong query ending on a dropped symbol
    for (int k = 0; k < 34; k++) add_sym(OP_QUERY, pick_sym(), k == 33);
    settle();
    if (errors == 0) begin
      $display("tb_local_sequence_alignment: PASS");
    end else begin
      $display("tb_local_sequence_alignment: FAIL");
    end
    $finish;
  end

  initial begin
    #(8_000_000);
    $display("tb_local_sequence_alignment: FAIL");
    $finish;
  end

endmodule
